FILE: hdl/tq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tq_pkg;
    localparam int NumTickets = 64;
    localparam int IdW = $clog2(NumTickets);
    localparam int CntW = $clog2(NumTickets + 1);

    typedef enum logic [1:0] {
        OP_ISSUE = 2'd0, OP_SERVE = 2'd1, OP_REMOVE = 2'd2, OP_PROMOTE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_NOT_QUEUED = 2'd2, ST_NO_FREE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE, S_READ, S_EXEC, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic read;
        logic exec;
    } t_cmd;
endpackage
`default_nettype wire

FILE: hdl/tq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module tq_datapath
    import tq_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cmd            i_cmd,
    input  wire logic [1:0]      i_op,
    input  wire logic [IdW-1:0]  i_ticket,
    output logic [IdW-1:0]       o_ticket_out,
    output logic [1:0]           o_status,
    output logic [CntW-1:0]      o_length
);
    logic [IdW-1:0] r_next [NumTickets];
    logic [IdW-1:0] r_prev [NumTickets];
    logic [IdW-1:0] r_fifo [NumTickets];
    logic [NumTickets-1:0] r_queued;
    logic [IdW-1:0] r_head, r_tail, r_rd, r_wr;
    logic [CntW-1:0] r_len, r_free, r_issued;
    t_op r_op;
    logic [IdW-1:0] r_tk, r_id;
    logic [IdW-1:0] r_nid, r_pid, r_fid;
    logic r_ok;
    logic [IdW-1:0] r_res;
    logic [1:0] r_st;

    // id under work: serve uses head
    always_comb begin
        r_id = (r_op == OP_SERVE) ? r_head : r_tk;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= t_op'(i_op);
            r_tk <= i_ticket;
        end
        if (i_cmd.read) begin
            r_nid <= r_next[r_id];
            r_pid <= r_prev[r_id];
            r_fid <= r_fifo[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued <= '0;
            r_head <= '0; r_tail <= '0; r_rd <= '0; r_wr <= '0;
            r_len <= '0; r_free <= '0; r_issued <= '0;
            r_res <= '0; r_st <= ST_OK;
        end else if (i_cmd.exec) begin
            r_res <= '0;
            r_st <= ST_OK;
            case (r_op)
                OP_ISSUE: begin
                    if (r_free == '0 && r_issued == CntW'(NumTickets)) begin
                        r_st <= ST_NO_FREE;
                    end else begin
                        logic [IdW-1:0] id;
                        if (r_free != '0) begin
                            id = r_fid;
                            r_rd <= r_rd + 1'b1;
                            r_free <= r_free - 1'b1;
                        end else begin
                            id = r_issued[IdW-1:0];
                            r_issued <= r_issued + 1'b1;
                        end
                        if (r_len == '0) begin
                            r_head <= id;
                        end else begin
                            r_next[r_tail] <= id;
                            r_prev[id] <= r_tail;
                        end
                        r_tail <= id;
                        r_queued[id] <= 1'b1;
                        r_len <= r_len + 1'b1;
                        r_res <= id;
                    end
                end
                default: begin
                    logic okq;
                    okq = (r_op == OP_SERVE) ? (r_len != '0)
                        : (CntW'(r_tk) < r_issued && r_queued[r_tk]);
                    if (!okq) begin
                        r_st <= (r_op == OP_SERVE) ? ST_EMPTY : ST_NOT_QUEUED;
                    end else if (r_op == OP_PROMOTE && r_id == r_head) begin
                        r_res <= r_id;
                    end else begin
                        r_res <= r_id;
                        if (r_len <= CntW'(1)) begin
                            r_head <= '0; r_tail <= '0;
                        end else if (r_id == r_head) begin
                            r_head <= r_nid;
                        end else if (r_id == r_tail) begin
                            r_tail <= r_pid;
                        end else begin
                            r_next[r_pid] <= r_nid;
                            r_prev[r_nid] <= r_pid;
                        end
                        if (r_op == OP_PROMOTE) begin
                            r_next[r_id] <= r_head;
                            r_prev[r_head] <= r_id;
                            r_head <= r_id;
                        end else begin
                            r_len <= r_len - 1'b1;
                            r_queued[r_id] <= 1'b0;
                            if (r_free < CntW'(NumTickets)) begin
                                r_fifo[r_wr] <= r_id;
                                r_wr <= r_wr + 1'b1;
                                r_free <= r_free + 1'b1;
                            end
                        end
                    end
                end
            endcase
        end
    end

    assign o_ticket_out = r_res;
    assign o_status = r_st;
    assign o_length = r_len;
endmodule
`default_nettype wire

FILE: hdl/tq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tq_ctrl
    import tq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_cmd      o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready = i_out_ready;
                if (i_out_ready) begin
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: hdl/ticket_queue_with_reuse.sv
`timescale 1ns / 1ps
`default_nettype none
// The result is valid in S_OUT, reached through the S_READ and S_EXEC states after the input transaction.
// Operations do not overlap: each does the link memory read then update before its result is offered.
// Next input is taken in the cycle the result is taken.
// Reset: synchronous active low; clears queue, pointers, counts and queued flags.
module ticket_queue_with_reuse
    import tq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // opcode[1:0], ticket[7:2]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // ticket_out[5:0], status[7:6], queue_length[14:8]
);
    t_cmd cmd;
    logic [IdW-1:0] tk_out;
    logic [1:0] st;
    logic [CntW-1:0] len;

    tq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(cmd)
    );

    tq_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_op(s_axis_tdata[1:0]), .i_ticket(s_axis_tdata[7:2]),
        .o_ticket_out(tk_out), .o_status(st), .o_length(len)
    );

    assign m_axis_tdata = {1'b0, len, st, tk_out};

`ifndef SYNTH
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        len <= CntW'(NumTickets)) else $error("length overflow");
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && st != ST_OK |-> tk_out == '0) else $error("id on failure");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd)) else $error("commands overlap");
`endif
endmodule
`default_nettype wire
